// ===== src/assert_macros.svh =====
// ---------------------------------------------------------------------------
// assert_macros.svh
// Concurrent assertion macros, empty when SYNTHESIS is defined.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS
`define ASSERT_PROP(lbl, clk, rst, prop) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error("assertion failed");
`define ASSERT_NEVER(lbl, clk, rst, expr) \
  lbl: assert property (@(posedge clk) disable iff (rst) !(expr)) \
    else $error("forbidden condition seen");
`else
`define ASSERT_PROP(lbl, clk, rst, prop)
`define ASSERT_NEVER(lbl, clk, rst, expr)
`endif

`endif

// ===== src/tpg_pkg.sv =====
// ---------------------------------------------------------------------------
// tpg_pkg
// Types, widths and register map of the trapezoidal profile generator.
// ---------------------------------------------------------------------------
package tpg_pkg;

  localparam int POSITION_WIDTH = 12;
  localparam int STEP_WIDTH     = 16;
  localparam int BLEND_WIDTH    = STEP_WIDTH - 1;
  localparam int DIFF_W         = POSITION_WIDTH + 1;

  localparam int OPND_W    = STEP_WIDTH + 1;
  localparam int MUL_A_W   = 2 * STEP_WIDTH + 1;
  localparam int MUL_B_W   = OPND_W;
  localparam int MUL_P_W   = MUL_A_W + MUL_B_W;
  localparam int MUL_CNT_W = $clog2(MUL_B_W);

  localparam int DEN_W     = 2 * STEP_WIDTH;
  localparam int NUM_W     = MUL_A_W + POSITION_WIDTH;
  localparam int Q_W       = POSITION_WIDTH;
  localparam int DIV_SH_W  = DEN_W + Q_W - 1;
  localparam int DIV_CNT_W = $clog2(Q_W);

  localparam int CFG_ADDR_W = 3;
  localparam int CFG_DATA_W = 32;

  localparam logic [CFG_ADDR_W-1:0] ADDR_TOTAL_STEPS = 3'd0;
  localparam logic [CFG_ADDR_W-1:0] ADDR_BLEND_STEPS = 3'd4;

  localparam logic [STEP_WIDTH-1:0]  TOTAL_STEPS_RESET = 16'd2000;
  localparam logic [BLEND_WIDTH-1:0] BLEND_STEPS_RESET = 15'd667;

  localparam logic ACTION_LOAD = 1'b0;
  localparam logic ACTION_TICK = 1'b1;

  typedef struct packed {
    logic                      action;
    logic [POSITION_WIDTH-1:0] dest_pulse;
  } in_t;

  typedef struct packed {
    logic [POSITION_WIDTH-1:0] pulse;
    logic                      moving;
    logic                      last;
  } out_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MUL_M,
    ST_MUL_P,
    ST_DIV,
    ST_EMIT
  } tpg_state_t;

endpackage

// ===== src/tpg_serial_mul.sv =====
// ---------------------------------------------------------------------------
// tpg_serial_mul
// Shift-add multiplier, one multiplier bit per cycle, LSB first.
// ---------------------------------------------------------------------------
module tpg_serial_mul (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  input  logic [tpg_pkg::MUL_A_W-1:0]   a,
  input  logic [tpg_pkg::MUL_B_W-1:0]   b,
  output logic                          done,
  output logic [tpg_pkg::MUL_P_W-1:0]   product
);
  import tpg_pkg::*;

  logic                 busy;
  logic [MUL_CNT_W-1:0] cnt;
  logic [MUL_A_W-1:0]   mcand;
  logic [MUL_P_W-1:0]   acc;
  logic [MUL_A_W:0]     upper_sum;

  assign upper_sum = {1'b0, acc[MUL_P_W-1:MUL_B_W]} + (acc[0] ? {1'b0, mcand} : '0);

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      cnt  <= '0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= MUL_CNT_W'(MUL_B_W - 1);
      end else if (busy) begin
        cnt <= cnt - 1'b1;
        if (cnt == '0) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      mcand <= a;
      acc   <= {{MUL_A_W{1'b0}}, b};
    end else if (busy) begin
      acc <= {upper_sum, acc[MUL_B_W-1:1]};
    end
  end

  assign product = acc;

endmodule

// ===== src/tpg_serial_div.sv =====
// ---------------------------------------------------------------------------
// tpg_serial_div
// Restoring divider, one quotient bit per cycle, MSB first.
// ---------------------------------------------------------------------------
module tpg_serial_div (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        start,
  input  logic [tpg_pkg::NUM_W-1:0]   num,
  input  logic [tpg_pkg::DEN_W-1:0]   den,
  output logic                        done,
  output logic [tpg_pkg::Q_W-1:0]     quotient,
  output logic                        rem_nz
);
  import tpg_pkg::*;

  logic                 busy;
  logic [DIV_CNT_W-1:0] cnt;
  logic [NUM_W-1:0]     rem;
  logic [DIV_SH_W-1:0]  dsh;
  logic [Q_W-1:0]       q;
  logic [NUM_W-1:0]     dsh_ext;
  logic                 fits;

  assign dsh_ext = NUM_W'(dsh);
  assign fits    = (rem >= dsh_ext);

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      cnt  <= '0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= DIV_CNT_W'(Q_W - 1);
      end else if (busy) begin
        cnt <= cnt - 1'b1;
        if (cnt == '0) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem <= num;
      dsh <= {den, {(Q_W-1){1'b0}}};
      q   <= '0;
    end else if (busy) begin
      if (fits) begin
        rem <= rem - dsh_ext;
      end
      q   <= {q[Q_W-2:0], fits};
      dsh <= dsh >> 1;
    end
  end

  assign quotient = q;
  assign rem_nz   = |rem;

endmodule

// ===== src/tpg_cfg.sv =====
// ---------------------------------------------------------------------------
// tpg_cfg
// APB register file: total step count and blend step count.
// ---------------------------------------------------------------------------
module tpg_cfg (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              psel,
  input  logic                              penable,
  input  logic                              pwrite,
  input  logic [tpg_pkg::CFG_ADDR_W-1:0]    paddr,
  input  logic [tpg_pkg::CFG_DATA_W-1:0]    pwdata,
  output logic [tpg_pkg::CFG_DATA_W-1:0]    prdata,
  output logic                              pready,
  output logic [tpg_pkg::STEP_WIDTH-1:0]    total_steps,
  output logic [tpg_pkg::BLEND_WIDTH-1:0]   blend_steps
);
  import tpg_pkg::*;

  logic wr_en;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (rst) begin
      total_steps <= TOTAL_STEPS_RESET;
      blend_steps <= BLEND_STEPS_RESET;
    end else if (wr_en) begin
      case (paddr)
        ADDR_TOTAL_STEPS: total_steps <= pwdata[STEP_WIDTH-1:0];
        ADDR_BLEND_STEPS: blend_steps <= pwdata[BLEND_WIDTH-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr)
      ADDR_TOTAL_STEPS: prdata = CFG_DATA_W'(total_steps);
      ADDR_BLEND_STEPS: prdata = CFG_DATA_W'(blend_steps);
      default:          prdata = '0;
    endcase
  end

endmodule

// ===== src/trapezoidal_profile_generator.sv =====
// ---------------------------------------------------------------------------
// trapezoidal_profile_generator
// Servo setpoint generator with a trapezoidal velocity profile.
//
// Channel  Direction  Handshake            Payload
// in       input      in_valid/in_stall    in_t  {action, dest_pulse}
// out      output     out_valid/out_stall  out_t {pulse, moving, last}
// cfg      input      APB, pready tied 1   total_steps @0x0, blend_steps @0x4
//
// A tick during a move runs two passes of the shift-add multiplier and then
// the restoring divider before its result is loaded for output.
// A load updates the move registers and stays idle; a tick while idle skips
// the arithmetic and emits the held position. Reset is synchronous and clears
// the position, step count and move state. A stalled result holds in the output
// register; the next input transfer is taken as soon as the result is loaded there.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module trapezoidal_profile_generator (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            in_valid,
  output logic                            in_stall,
  input  tpg_pkg::in_t                    in_data,
  output logic                            out_valid,
  input  logic                            out_stall,
  output tpg_pkg::out_t                   out_data,
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [tpg_pkg::CFG_ADDR_W-1:0]  paddr,
  input  logic [tpg_pkg::CFG_DATA_W-1:0]  pwdata,
  output logic [tpg_pkg::CFG_DATA_W-1:0]  prdata,
  output logic                            pready
);
  import tpg_pkg::*;

  tpg_state_t state, state_next;

  logic [STEP_WIDTH-1:0]     total_steps;
  logic [BLEND_WIDTH-1:0]    blend_steps;

  logic [POSITION_WIDTH-1:0] start_position;
  logic [POSITION_WIDTH-1:0] goal_position;
  logic [POSITION_WIDTH-1:0] current_output;
  logic [STEP_WIDTH-1:0]     step_index;
  logic                      running;

  logic                      decel;
  logic                      fin;
  logic [STEP_WIDTH-1:0]     n_step;
  logic                      emit_move;
  out_t                      res;

  logic                      accept;
  logic                      start_m;
  logic                      start_p;
  logic                      div_start;
  logic                      res_load;
  logic                      idle_emit;
  logic                      emit_fire;

  logic [STEP_WIDTH-1:0]     n_total;
  logic [BLEND_WIDTH-1:0]    blend_lo;
  logic [BLEND_WIDTH-1:0]    b_c;
  logic [STEP_WIDTH-1:0]     n_c;
  logic [STEP_WIDTH-1:0]     nb;
  logic [STEP_WIDTH-1:0]     rem_steps;
  logic                      accel_c;
  logic                      cruise_c;
  logic [OPND_W-1:0]         op_a;
  logic [OPND_W-1:0]         op_b;

  logic [DIFF_W-1:0]         diff;
  logic [DIFF_W-1:0]         diff_abs;
  logic                      neg;
  logic [POSITION_WIDTH-1:0] base;
  logic [POSITION_WIDTH-1:0] q_adj;
  logic [POSITION_WIDTH-1:0] pulse_calc;

  logic                      mul_start;
  logic [MUL_A_W-1:0]        mul_a;
  logic [MUL_B_W-1:0]        mul_b;
  logic                      mul_done;
  logic [MUL_P_W-1:0]        mul_prod;
  logic                      den_done;
  logic [MUL_P_W-1:0]        den_prod;
  logic                      div_done;
  logic [Q_W-1:0]            div_q;
  logic                      div_rem_nz;

  tpg_cfg u_cfg (
    .clk         (clk),
    .rst         (rst),
    .psel        (psel),
    .penable     (penable),
    .pwrite      (pwrite),
    .paddr       (paddr),
    .pwdata      (pwdata),
    .prdata      (prdata),
    .pready      (pready),
    .total_steps (total_steps),
    .blend_steps (blend_steps)
  );

  // clamp step counts and pick the profile segment
  always_comb begin
    n_total   = (total_steps < STEP_WIDTH'(2)) ? STEP_WIDTH'(2) : total_steps;
    blend_lo  = (blend_steps == '0) ? BLEND_WIDTH'(1) : blend_steps;
    b_c       = (blend_lo > n_total[STEP_WIDTH-1:1]) ? n_total[STEP_WIDTH-1:1] : blend_lo;
    n_c       = (step_index > n_total) ? n_total : step_index;
    nb        = n_total - STEP_WIDTH'(b_c);
    rem_steps = n_total - n_c;
    accel_c   = (n_c <= STEP_WIDTH'(b_c));
    cruise_c  = (n_c < nb);
    if (accel_c) begin
      op_a = OPND_W'(n_c);
      op_b = OPND_W'(n_c);
    end else if (cruise_c) begin
      op_a = {n_c, 1'b0} - OPND_W'(b_c);
      op_b = OPND_W'(b_c);
    end else begin
      op_a = OPND_W'(rem_steps);
      op_b = OPND_W'(rem_steps);
    end
  end

  always_comb begin
    diff       = {1'b0, goal_position} - {1'b0, start_position};
    diff_abs   = diff[DIFF_W-1] ? (~diff + 1'b1) : diff;
    neg        = diff[DIFF_W-1] ^ decel;
    base       = decel ? goal_position : start_position;
    q_adj      = div_q + POSITION_WIDTH'(neg && div_rem_nz);
    pulse_calc = neg ? (base - q_adj) : (base + q_adj);
  end

  assign mul_start = start_m || start_p;
  assign mul_a     = (state == ST_IDLE) ? MUL_A_W'(op_a) : mul_prod[MUL_A_W-1:0];
  assign mul_b     = (state == ST_IDLE) ? op_b : MUL_B_W'(diff_abs[POSITION_WIDTH-1:0]);

  tpg_serial_mul u_mul (
    .clk     (clk),
    .rst     (rst),
    .start   (mul_start),
    .a       (mul_a),
    .b       (mul_b),
    .done    (mul_done),
    .product (mul_prod)
  );

  tpg_serial_mul u_den_mul (
    .clk     (clk),
    .rst     (rst),
    .start   (start_m),
    .a       (MUL_A_W'(nb)),
    .b       (MUL_B_W'(b_c)),
    .done    (den_done),
    .product (den_prod)
  );

  tpg_serial_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .num      (mul_prod[NUM_W-1:0]),
    .den      ({den_prod[DEN_W-2:0], 1'b0}),
    .done     (div_done),
    .quotient (div_q),
    .rem_nz   (div_rem_nz)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    in_stall   = 1'b1;
    accept     = 1'b0;
    start_m    = 1'b0;
    start_p    = 1'b0;
    div_start  = 1'b0;
    res_load   = 1'b0;
    idle_emit  = 1'b0;
    emit_fire  = 1'b0;
    case (state)
      ST_IDLE: begin
        in_stall = 1'b0;
        accept   = in_valid;
        if (in_valid && in_data.action == ACTION_TICK) begin
          if (running) begin
            start_m    = 1'b1;
            state_next = ST_MUL_M;
          end else begin
            idle_emit  = 1'b1;
            state_next = ST_EMIT;
          end
        end
      end
      ST_MUL_M: begin
        if (mul_done) begin
          start_p    = 1'b1;
          state_next = ST_MUL_P;
        end
      end
      ST_MUL_P: begin
        if (mul_done) begin
          div_start  = 1'b1;
          state_next = ST_DIV;
        end
      end
      ST_DIV: begin
        if (div_done) begin
          res_load   = 1'b1;
          state_next = ST_EMIT;
        end
      end
      ST_EMIT: begin
        if (!out_valid || !out_stall) begin
          emit_fire  = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      start_position <= '0;
      goal_position  <= '0;
      current_output <= '0;
      step_index     <= '0;
      running        <= 1'b0;
    end else if (accept && in_data.action == ACTION_LOAD) begin
      goal_position  <= in_data.dest_pulse;
      start_position <= current_output;
      step_index     <= '0;
      running        <= 1'b1;
    end else if (emit_fire && emit_move) begin
      current_output <= res.pulse;
      if (fin) begin
        start_position <= goal_position;
        running        <= 1'b0;
        step_index     <= '0;
      end else begin
        step_index <= n_step + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start_m) begin
      decel     <= !accel_c && !cruise_c;
      fin       <= (n_c == n_total);
      n_step    <= n_c;
      emit_move <= 1'b1;
    end else if (idle_emit) begin
      res       <= '{pulse: current_output, moving: 1'b0, last: 1'b0};
      emit_move <= 1'b0;
    end else if (res_load) begin
      res <= '{pulse: pulse_calc, moving: 1'b1, last: fin};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (emit_fire) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit_fire) begin
      out_data <= res;
    end
  end

  `ASSERT_PROP(a_idle_step_zero, clk, rst, !running |-> (step_index == '0))
  `ASSERT_PROP(a_mul_done_state, clk, rst, mul_done |-> (state == ST_MUL_M || state == ST_MUL_P))
  `ASSERT_PROP(a_den_with_mul, clk, rst, den_done |-> (mul_done && state == ST_MUL_M))
  `ASSERT_PROP(a_last_moving, clk, rst, (out_valid && out_data.last) |-> out_data.moving)
  `ASSERT_PROP(a_out_from_emit, clk, rst, $rose(out_valid) |-> ($past(state) == ST_EMIT))
  `ASSERT_NEVER(a_div_in_mul, clk, rst, div_done && mul_done)

endmodule

// ===== sim/testbench.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// testbench
// Self-checking bench for the trapezoidal profile generator. Loads and ticks
// are driven through the valid/stall input channel and setpoints are checked
// against an in-bench profile predictor. The run steps through several
// total/blend register settings, including out-of-range and extreme values,
// with random sender gaps and receiver stalls and one long output hold.
// ---------------------------------------------------------------------------
module testbench;
  import tpg_pkg::*;

  localparam int WATCHDOG_LIMIT = 5000;
  localparam int HOLD_CYCLES    = 600;
  localparam int HOLD_AFTER     = 200;
  localparam int PHASE_QUOTA    = 85;
  localparam int MOVE_TICK_CAP  = 60;
  localparam int NUM_FIXED      = 7;
  localparam int NUM_RANDOM     = 6;
  localparam int SETTLE_CYCLES  = 8;
  localparam int END_CYCLES     = 60;

  localparam logic [CFG_DATA_W-1:0] STEPS_MASK = (32'd1 << STEP_WIDTH) - 1;
  localparam logic [CFG_DATA_W-1:0] BLEND_MASK = (32'd1 << BLEND_WIDTH) - 1;

  class setpoint_scoreboard;
    logic [STEP_WIDTH-1:0]     total_steps;
    logic [BLEND_WIDTH-1:0]    blend_steps;
    logic [POSITION_WIDTH-1:0] move_start;
    logic [POSITION_WIDTH-1:0] move_goal;
    logic [POSITION_WIDTH-1:0] setpoint;
    logic [STEP_WIDTH-1:0]     step_count;
    bit                        in_move;
    out_t                      pending_setpoints[$];
    int                        errors;
    int                        loads;
    int                        ticks;
    int                        moves_done;

    function new();
      total_steps = TOTAL_STEPS_RESET;
      blend_steps = BLEND_STEPS_RESET;
      move_start  = '0;
      move_goal   = '0;
      setpoint    = '0;
      step_count  = '0;
      in_move     = 1'b0;
      errors      = 0;
      loads       = 0;
      ticks       = 0;
      moves_done  = 0;
    endfunction

    function void set_config(logic [STEP_WIDTH-1:0] steps, logic [BLEND_WIDTH-1:0] blend);
      total_steps = steps;
      blend_steps = blend;
    endfunction

    function longint steps_used();
      longint n;
      n = total_steps;
      if (n < 2) n = 2;
      return n;
    endfunction

    function longint blend_used(longint n);
      longint b;
      b = blend_steps;
      if (b < 1) b = 1;
      if (b > n / 2) b = n / 2;
      return b;
    endfunction

    function longint floor_quot(longint num, longint den);
      longint q;
      q = num / den;
      if (num % den != 0 && num < 0) q = q - 1;
      return q;
    endfunction

    function logic [POSITION_WIDTH-1:0] profile_at(longint k, longint n, longint b);
      longint s, g, d, den, v, r;
      s   = move_start;
      g   = move_goal;
      d   = g - s;
      den = 2 * b * (n - b);
      if (k <= b) begin
        v = s + floor_quot(d * k * k, den);
      end else if (k < n - b) begin
        v = s + floor_quot(d * (2 * k - b), 2 * (n - b));
      end else begin
        r = n - k;
        v = g + floor_quot(-d * r * r, den);
      end
      return v[POSITION_WIDTH-1:0];
    endfunction

    function void note_transfer(in_t item);
      longint n, b, k;
      out_t   want;
      if (item.action == ACTION_LOAD) begin
        move_goal  = item.dest_pulse;
        move_start = setpoint;
        step_count = '0;
        in_move    = 1'b1;
        loads++;
      end else begin
        ticks++;
        if (!in_move) begin
          want.pulse  = setpoint;
          want.moving = 1'b0;
          want.last   = 1'b0;
        end else begin
          n = steps_used();
          b = blend_used(n);
          k = step_count;
          if (k > n) k = n;
          setpoint    = profile_at(k, n, b);
          want.pulse  = setpoint;
          want.moving = 1'b1;
          want.last   = (k >= n);
          if (k >= n) begin
            move_start = move_goal;
            in_move    = 1'b0;
            step_count = '0;
            moves_done++;
          end else begin
            step_count = STEP_WIDTH'(k + 1);
          end
        end
        pending_setpoints.push_back(want);
      end
    endfunction

    function void check_setpoint(out_t got);
      out_t want;
      if (pending_setpoints.size() == 0) begin
        $error("unexpected result: pulse %0d moving %0b last %0b",
               got.pulse, got.moving, got.last);
        errors++;
        return;
      end
      want = pending_setpoints.pop_front();
      if (got.pulse !== want.pulse) begin
        $error("pulse: expected %0d, got %0d", want.pulse, got.pulse);
        errors++;
      end
      if (got.moving !== want.moving) begin
        $error("moving: expected %0b, got %0b", want.moving, got.moving);
        errors++;
      end
      if (got.last !== want.last) begin
        $error("last: expected %0b, got %0b", want.last, got.last);
        errors++;
      end
    endfunction
  endclass

  logic                      clk       = 1'b0;
  logic                      rst       = 1'b1;
  logic                      in_valid  = 1'b0;
  in_t                       in_data   = '0;
  logic                      out_stall = 1'b0;
  logic                      psel      = 1'b0;
  logic                      penable   = 1'b0;
  logic                      pwrite    = 1'b0;
  logic [CFG_ADDR_W-1:0]     paddr     = '0;
  logic [CFG_DATA_W-1:0]     pwdata    = '0;
  logic                      in_stall;
  logic                      out_valid;
  out_t                      out_data;
  logic [CFG_DATA_W-1:0]     prdata;
  logic                      pready;

  setpoint_scoreboard        sb = new();
  bit                        calm = 1'b0;
  bit                        held = 1'b0;
  int                        results_seen = 0;
  int                        sent_items = 0;
  int                        quiet_cycles = 0;
  int                        settings_used = 0;
  logic [POSITION_WIDTH-1:0] settled_pos = '0;

  int unsigned fixed_total [NUM_FIXED] = '{0, 1, 17, 40, 65535, 2000, 5};
  int unsigned fixed_blend [NUM_FIXED] = '{0, 32767, 32767, 3, 32767, 667, 2};

  trapezoidal_profile_generator i_dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .psel      (psel),
    .penable   (penable),
    .pwrite    (pwrite),
    .paddr     (paddr),
    .pwdata    (pwdata),
    .prdata    (prdata),
    .pready    (pready)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  always @(posedge clk) begin
    if (!rst) begin
      if (in_valid && !in_stall) sb.note_transfer(in_data);
      if (out_valid && !out_stall) begin
        sb.check_setpoint(out_data);
        results_seen++;
      end
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
        quiet_cycles = 0;
      end else begin
        quiet_cycles++;
      end
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("timeout after %0d cycles without a transfer", quiet_cycles);
        $display("DONE: errors detected");
        $finish;
      end
    end
  end

  // receiver: random stall bursts, one long hold to back up the input
  initial begin
    wait (!rst);
    forever begin
      if (!calm && !held && results_seen >= HOLD_AFTER) begin
        held = 1'b1;
        out_stall <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
        out_stall <= 1'b0;
        @(posedge clk);
      end else if (!calm && $urandom_range(0, 3) == 0) begin
        out_stall <= 1'b1;
        repeat ($urandom_range(1, 16)) @(posedge clk);
        out_stall <= 1'b0;
        @(posedge clk);
      end else begin
        repeat ($urandom_range(1, 40)) @(posedge clk);
      end
    end
  end

  task automatic send_item(input logic action, input logic [POSITION_WIDTH-1:0] target);
    in_t item;
    item.action     = action;
    item.dest_pulse = target;
    if (!calm && $urandom_range(0, 7) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 16)) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= item;
    do @(posedge clk); while (in_stall);
    sent_items++;
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (sb.pending_setpoints.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_ADDR_W-1:0] addr,
                           input logic [CFG_DATA_W-1:0] value,
                           input logic [CFG_DATA_W-1:0] mask);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= addr;
    pwdata  <= ($urandom() & ~mask) | (value & mask);
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk);
  endtask

  task automatic configure(input int unsigned steps, input int unsigned blend);
    write_reg(ADDR_TOTAL_STEPS, steps, STEPS_MASK);
    write_reg(ADDR_BLEND_STEPS, blend, BLEND_MASK);
    sb.set_config(steps[STEP_WIDTH-1:0], blend[BLEND_WIDTH-1:0]);
    settings_used++;
  endtask

  function automatic logic [POSITION_WIDTH-1:0] pick_target();
    case ($urandom_range(0, 5))
      0: return '0;
      1: return '1;
      2: return settled_pos;
      3: return settled_pos ^ POSITION_WIDTH'($urandom_range(1, 15));
      default: return POSITION_WIDTH'($urandom());
    endcase
  endfunction

  task automatic run_phase(input int quota);
    int                        first, n, len, k;
    logic [POSITION_WIDTH-1:0] target;
    first = sent_items;
    while (sent_items - first < quota) begin
      case ($urandom_range(0, 9))
        0, 1, 2, 3, 4, 5, 6: begin
          target = pick_target();
          n      = int'(sb.steps_used());
          len    = (n + 1 > MOVE_TICK_CAP) ? MOVE_TICK_CAP : n + 1;
          if ($urandom_range(0, 4) == 0) len = $urandom_range(0, len - 1);
          send_item(ACTION_LOAD, target);
          for (k = 0; k < len; k++) send_item(ACTION_TICK, POSITION_WIDTH'($urandom()));
          if (len == n + 1) settled_pos = target;
          repeat ($urandom_range(0, 2)) send_item(ACTION_TICK, POSITION_WIDTH'($urandom()));
        end
        7, 8: begin
          repeat ($urandom_range(1, 6))
            send_item(1'($urandom_range(0, 1)), POSITION_WIDTH'($urandom()));
        end
        default: begin
          repeat ($urandom_range(1, 3)) send_item(ACTION_TICK, POSITION_WIDTH'($urandom()));
        end
      endcase
    end
  endtask

  initial begin
    repeat (6) @(posedge clk);
    rst <= 1'b0;

    // reset settings: idle tick, start a long move, restart it midway
    send_item(ACTION_TICK, '0);
    send_item(ACTION_LOAD, '1);
    repeat (3) send_item(ACTION_TICK, '0);
    send_item(ACTION_LOAD, '0);
    send_item(ACTION_TICK, '1);
    drain();

    // shortest move: full move, idle hold, equal start and goal, restart
    configure(2, 1);
    send_item(ACTION_LOAD, '1);
    repeat (3) send_item(ACTION_TICK, '0);
    send_item(ACTION_TICK, '1);
    send_item(ACTION_LOAD, '1);
    repeat (3) send_item(ACTION_TICK, '0);
    send_item(ACTION_LOAD, '0);
    send_item(ACTION_TICK, '0);
    send_item(ACTION_LOAD, 12'h555);
    repeat (3) send_item(ACTION_TICK, 12'hAAA);
    settled_pos = 12'h555;

    for (int i = 0; i < NUM_FIXED; i++) begin
      drain();
      configure(fixed_total[i], fixed_blend[i]);
      run_phase(PHASE_QUOTA);
    end
    for (int i = 0; i < NUM_RANDOM; i++) begin
      if (i >= NUM_RANDOM - 2) calm = 1'b1;
      drain();
      configure($urandom_range(2, 64), $urandom_range(0, 40));
      run_phase(PHASE_QUOTA);
    end

    drain();
    repeat (END_CYCLES) @(posedge clk);
    if (sb.pending_setpoints.size() != 0) begin
      $error("%0d expected results never arrived", sb.pending_setpoints.size());
      sb.errors++;
    end
    $display("Ran %0d transfers: %0d loads, %0d ticks, %0d finished moves",
             sent_items, sb.loads, sb.ticks, sb.moves_done);
    $display("over %0d register settings, with a %0d-cycle output hold",
             settings_used, HOLD_CYCLES);
    if (sb.errors == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
+incdir+src
src/tpg_pkg.sv
src/tpg_serial_mul.sv
src/tpg_serial_div.sv
src/tpg_cfg.sv
src/trapezoidal_profile_generator.sv
sim/testbench.sv
